// ----- hw/rtl/seven_segment_number_formatter_macros.svh -----
// assertion helpers shared by the formatter modules
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_MACROS_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_MACROS_SVH

// antecedent on one edge implies consequent on the same edge
`define SSNF_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define SSNF_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/ssnf_pkg.sv -----
`default_nettype none
package ssnf_pkg;

	localparam int VALUE_W = 28;
	localparam int DOT_W   = 4;
	localparam int MAG_W   = 27;
	localparam int ADDR_W  = 4;
	localparam int DATA_W  = 8;
	localparam int DIGIT_W = 4;
	localparam int POW_N   = 9;
	localparam int POW_IDX_W = 4;

	typedef logic [MAG_W-1:0] mag_t;

	localparam logic [DATA_W-1:0] CODE_MINUS = 8'd10;
	localparam logic [DATA_W-1:0] CODE_BLANK = 8'h0F;
	localparam logic [DATA_W-1:0] DOT_BIT    = 8'h80;

	// powers of ten up to 10^8
	localparam mag_t POW10 [POW_N] = '{
		27'd1, 27'd10, 27'd100, 27'd1000, 27'd10000, 27'd100000,
		27'd1000000, 27'd10000000, 27'd100000000
	};

	// one classified request waiting for the digit sequencer
	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [DOT_W-1:0] dot;
		mag_t             mag;
	} job_t;

endpackage
`default_nettype wire

// ----- hw/rtl/seven_segment_number_formatter.sv -----
// Signed number formatter for a code-B seven-segment digit driver. Each input
// request carries a 28-bit two's complement value and a decimal-point digit index
// (0 is rightmost, an index past the digits in use means no dot). For every
// request the block emits DIGIT_COUNT digit-register writes as address/data
// pairs, leftmost digit first, address 1 last with tlast set. A negative value
// first writes the minus code 10 at address DIGIT_COUNT and shows its magnitude
// on the remaining digits. Leading zeros are written as blank (0x0F) until a
// nonzero digit or the dot digit; the dot digit gets bit 7 except on the
// rightmost digit. Values past the displayable range saturate to all nines and
// raise tuser on every write of the run. Rate: one write per cycle while the
// output is taken, all from the single digit extraction unit in the back end;
// when the next request is already queued, its first write follows the last
// write of the previous run with no gap. A two-entry queue between the input
// classifier and the digit sequencer absorbs input while the output is stalled.
// A request passes the queue and the sequencer load before its first write.
`default_nettype none
module seven_segment_number_formatter #(
	parameter int DIGIT_COUNT = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [27:0] value, [31:28] dot_position
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [3:0] digit_address, [11:4] digit_data, [15:12] zero
	output logic             m_axis_tlast,
	output logic [0:0]       m_axis_tuser   // [0] overflow
);
	import ssnf_pkg::*;

	// front end: classify the request into sign, overflow flag, saturated magnitude and dot
	job_t              front_job;
	logic              push;

	// queue to back end
	logic              q_ready;
	logic              q_valid;
	job_t              q_job;
	logic              q_pop;

	// back end result
	logic [ADDR_W-1:0] res_address;
	logic [DATA_W-1:0] res_data;

	assign s_axis_tready = q_ready;
	assign push          = s_axis_tvalid && q_ready;

	ssnf_front #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_front (
		.value        (s_axis_tdata[VALUE_W-1:0]),
		.dot_position (s_axis_tdata[VALUE_W+DOT_W-1:VALUE_W]),
		.job          (front_job)
	);

	ssnf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (front_job),
		.ready      (q_ready),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_job   (q_job)
	);

	// back end: one digit per cycle while the output is taken, into a registered output slot
	ssnf_back #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (q_valid),
		.job          (q_job),
		.job_pop      (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_address  (res_address),
		.out_data     (res_data),
		.out_last     (m_axis_tlast),
		.out_overflow (m_axis_tuser[0])
	);

	// pack the write, zero fill to whole bytes
	assign m_axis_tdata = {4'd0, res_data, res_address};

endmodule
`default_nettype wire

// ----- hw/rtl/ssnf_front.sv -----
`default_nettype none
module ssnf_front #(
	parameter int DIGIT_COUNT = 8
) (
	input  wire logic [ssnf_pkg::VALUE_W-1:0] value,
	input  wire logic [ssnf_pkg::DOT_W-1:0]   dot_position,
	output ssnf_pkg::job_t                    job
);
	import ssnf_pkg::*;

	localparam logic [VALUE_W-1:0] LIMIT_POS = VALUE_W'(POW10[DIGIT_COUNT] - 27'd1);
	localparam logic [VALUE_W-1:0] LIMIT_NEG = VALUE_W'(POW10[DIGIT_COUNT-1] - 27'd1);

	logic                 neg;
	logic [VALUE_W-1:0]   mag_full;
	logic [VALUE_W-1:0]   limit;
	logic                 ovf;

	// magnitude of the two's complement value, most negative value included
	always_comb begin
		neg      = value[VALUE_W-1];
		mag_full = neg ? (VALUE_W'(0) - value) : value;
		limit    = neg ? LIMIT_NEG : LIMIT_POS;
		ovf      = (mag_full > limit);
		job.neg  = neg;
		job.ovf  = ovf;
		job.dot  = dot_position;
		job.mag  = ovf ? limit[MAG_W-1:0] : mag_full[MAG_W-1:0];
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ssnf_queue.sv -----
`default_nettype none
`include "seven_segment_number_formatter_macros.svh"
module ssnf_queue (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  ssnf_pkg::job_t      push_job,
	output logic                ready,
	input  wire logic           pop,
	output logic                head_valid,
	output ssnf_pkg::job_t      head_job
);
	import ssnf_pkg::*;

	localparam int DEPTH = 2;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign ready      = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers wrap naturally, depth is a power of two
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`SSNF_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(DEPTH), "queue overfilled")
	`SSNF_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, count_q != '0, "pop from empty queue")
	`SSNF_ASSERT_NEXT(a_push_grows, clk, arst_n, push && !pop, count_q == $past(count_q) + 1'b1, "count lost a push")

endmodule
`default_nettype wire

// ----- hw/rtl/ssnf_back.sv -----
`default_nettype none
`include "seven_segment_number_formatter_macros.svh"
module ssnf_back #(
	parameter int DIGIT_COUNT = 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        job_valid,
	input  ssnf_pkg::job_t                   job,
	output logic                             job_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ssnf_pkg::ADDR_W-1:0]      out_address,
	output logic [ssnf_pkg::DATA_W-1:0]      out_data,
	output logic                             out_last,
	output logic                             out_overflow
);
	import ssnf_pkg::*;

	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [IDX_W-1:0]  K_TOP    = IDX_W'(DIGIT_COUNT - 1);
	localparam logic [IDX_W-1:0]  K_NEG    = IDX_W'((DIGIT_COUNT > 1) ? DIGIT_COUNT - 2 : 0);
	localparam logic [ADDR_W-1:0] ADDR_TOP = ADDR_W'(DIGIT_COUNT);
	localparam logic              MINUS_IS_LAST = (DIGIT_COUNT == 1);

	logic              busy_q;
	logic              minus_q;
	logic              lead_q;
	logic [IDX_W-1:0]  k_q;
	mag_t              rem_q;
	logic [DOT_W-1:0]  dot_q;
	logic              ovf_q;
	logic              out_valid_q;
	logic [ADDR_W-1:0] out_address_q;
	logic [DATA_W-1:0] out_data_q;
	logic              out_last_q;
	logic              out_ovf_q;

	logic              step;
	logic              step_last;
	logic              load;
	mag_t              pow;
	mag_t              mult;
	mag_t              sub;
	mag_t              rem_next;
	logic [DIGIT_W-1:0] dv;
	logic              is_dot;
	logic              lead_next;
	logic [ADDR_W-1:0] addr_next;
	logic [DATA_W-1:0] data_next;

	assign step      = busy_q && (!out_valid_q || out_ready);
	assign step_last = minus_q ? MINUS_IS_LAST : (k_q == '0);
	assign load      = job_valid && (!busy_q || (step && step_last));
	assign job_pop   = load;

	// digit extraction: nine parallel compares against multiples of 10^k
	always_comb begin
		pow  = POW10[POW_IDX_W'(k_q)];
		dv   = '0;
		sub  = '0;
		mult = '0;
		for (int j = 1; j < 10; j++) begin
			mult = pow * MAG_W'(j);
			if (rem_q >= mult) begin
				dv  = DIGIT_W'(j);
				sub = mult;
			end
		end
		rem_next  = rem_q - sub;
		is_dot    = (DOT_W'(k_q) == dot_q);
		lead_next = lead_q || (dv != '0) || is_dot;
		if (minus_q) begin
			addr_next = ADDR_TOP;
			data_next = CODE_MINUS;
		end else begin
			addr_next = ADDR_W'(k_q) + 1'b1;
			if (is_dot) begin
				data_next = {{(DATA_W-DIGIT_W){1'b0}}, dv} | ((k_q != '0) ? DOT_BIT : '0);
			end else if (lead_next || (k_q == '0)) begin
				data_next = {{(DATA_W-DIGIT_W){1'b0}}, dv};
			end else begin
				data_next = CODE_BLANK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			minus_q     <= 1'b0;
			lead_q      <= 1'b0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q  <= 1'b1;
				minus_q <= job.neg;
				lead_q  <= 1'b0;
				k_q     <= job.neg ? K_NEG : K_TOP;
			end else if (step && step_last) begin
				busy_q  <= 1'b0;
				minus_q <= 1'b0;
			end else if (step) begin
				if (minus_q) begin
					minus_q <= 1'b0;
				end else begin
					lead_q <= lead_next;
					k_q    <= k_q - 1'b1;
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= job.mag;
			dot_q <= job.dot;
			ovf_q <= job.ovf;
		end else if (step && !minus_q) begin
			rem_q <= rem_next;
		end
		if (step) begin
			out_address_q <= addr_next;
			out_data_q    <= data_next;
			out_last_q    <= step_last;
			out_ovf_q     <= ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_address  = out_address_q;
	assign out_data     = out_data_q;
	assign out_last     = out_last_q;
	assign out_overflow = out_ovf_q;

	`SSNF_ASSERT_IMPL(a_last_rightmost, clk, arst_n, out_valid_q && out_last_q, out_address_q == 4'd1, "run ended off the rightmost digit")
	`SSNF_ASSERT_IMPL(a_no_blank_last, clk, arst_n, out_valid_q && out_last_q, out_data_q != CODE_BLANK, "rightmost digit blanked")
	`SSNF_ASSERT_IMPL(a_minus_needs_busy, clk, arst_n, minus_q, busy_q, "minus pending while idle")

endmodule
`default_nettype wire
